FILE: rtl/core/ttlc_pkg.sv
// ----------------------------------------------------------------------------
// ttlc_pkg
// Shared types and constants for the direct-mapped cache with entry lifetime:
// operation codes, the stored entry layout and controller/datapath signals.
// ----------------------------------------------------------------------------
`default_nettype none

package ttlc_pkg;

  localparam int unsigned HASH_SHIFT = 4;
  localparam logic [31:0] LIFETIME_RESET = 32'd1000;

  typedef enum logic [1:0] {
    OP_STORE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_INVAL  = 2'd2,
    OP_FLUSH  = 2'd3
  } op_e;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] cnt_c;
    logic [15:0] cnt_b;
    logic [15:0] cnt_a;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic gen_inc;
    logic mem_rd;
    logic sweep_wr;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic sweep_last;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/ttlc_slot.sv
// ----------------------------------------------------------------------------
// ttlc_slot
// Slot index unit: (id xor id>>4) modulo the entry count. A power-of-two count
// takes the low bits into a register; any other count reduces one nibble a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttlc_slot #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [31:0]                key_i,
  output logic      [$clog2(ENTRIES)-1:0] slot_o,
  output logic                            done_o
);
  import ttlc_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  logic [31:0] mix;
  assign mix = key_i ^ (key_i >> HASH_SHIFT);

  if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_pow2
    logic [IDX_W-1:0] slot_q;
    logic             done_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        slot_q <= mix[IDX_W-1:0];
      end
    end

    assign slot_o = slot_q;
    assign done_o = done_q;
  end else begin : g_mod
    localparam int unsigned RW = IDX_W + 4;
    localparam logic [RW-1:0] MODV = RW'(ENTRIES);
    localparam logic [3:0] NIB_CNT = 4'd8;

    logic [31:0]      v_q;
    logic [IDX_W-1:0] r_q;
    logic [IDX_W-1:0] r_d;
    logic [3:0]       cnt_q;
    logic             done_q;
    logic [RW-1:0]    acc;

    // conditional subtract of 8m, 4m, 2m, m
    always_comb begin
      acc = {r_q, v_q[31:28]};
      for (int k = 3; k >= 0; k--) begin
        if (acc >= (MODV << k)) begin
          acc = acc - (MODV << k);
        end
      end
      r_d = acc[IDX_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q  <= '0;
        done_q <= 1'b0;
      end else if (start_i) begin
        cnt_q  <= NIB_CNT;
        done_q <= 1'b0;
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 4'd1;
        done_q <= (cnt_q == 4'd1);
      end else begin
        done_q <= 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        v_q <= mix;
        r_q <= '0;
      end else if (cnt_q != '0) begin
        v_q <= v_q << 4;
        r_q <= r_d;
      end
    end

    assign slot_o = r_q;
    assign done_o = done_q;
  end

endmodule

`default_nettype wire

FILE: rtl/core/ttlc_dp.sv
// ----------------------------------------------------------------------------
// ttlc_dp
// Datapath: captured request, entry memory with registered read, clear sweep
// counter, hit evaluation, result registers, lifetime and flush generation.
// ----------------------------------------------------------------------------
`default_nettype none

module ttlc_dp #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  ttlc_pkg::dp_cmd_t      cmd_i,
  output ttlc_pkg::dp_sts_t      sts_o,
  input  ttlc_pkg::op_e          op_i,
  input  wire logic [31:0]       key_id_i,
  input  wire logic [31:0]       now_ms_i,
  input  wire logic [15:0]       count_a_in_i,
  input  wire logic [15:0]       count_b_in_i,
  input  wire logic [15:0]       count_c_in_i,
  input  wire logic              cfg_we_i,
  input  wire logic [31:0]       cfg_wdata_i,
  output logic                   hit_o,
  output logic      [15:0]       count_a_out_o,
  output logic      [15:0]       count_b_out_o,
  output logic      [15:0]       count_c_out_o,
  output logic      [30:0]       generation_o
);
  import ttlc_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  op_e         op_q;
  logic [31:0] key_q;
  logic [31:0] now_q;
  logic [15:0] a_q, b_q, c_q;
  logic [31:0] lifetime_q;
  logic [31:0] gen_q;
  logic [IDX_W-1:0] sweep_q;
  entry_t      rd_q;
  entry_t      mem [ENTRIES];

  logic [IDX_W-1:0] slot;
  logic             hash_done;

  logic             hit_q;
  logic [15:0]      oa_q, ob_q, oc_q;

  logic             match;
  logic [31:0]      age;
  logic             hit_d;
  logic             sweep_last;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  ttlc_slot #(
    .ENTRIES (ENTRIES)
  ) u_slot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.capture),
    .key_i   (key_id_i),
    .slot_o  (slot),
    .done_o  (hash_done)
  );

  always_comb begin
    match      = (rd_q.key == key_q);
    age        = now_q - rd_q.stamp;
    hit_d      = (op_q == OP_LOOKUP) && match && (rd_q.stamp != '0) && (age <= lifetime_q);
    sweep_last = (sweep_q == LAST_IDX);

    wr_en   = 1'b0;
    wr_addr = slot;
    wr_data = rd_q;
    if (cmd_i.sweep_wr) begin
      wr_en   = 1'b1;
      wr_addr = sweep_q;
      wr_data = '0;
    end else if (cmd_i.exec && (op_q == OP_STORE)) begin
      wr_en   = 1'b1;
      wr_data = '{key: key_q, cnt_c: c_q, cnt_b: b_q, cnt_a: a_q, stamp: now_q};
    end else if (cmd_i.exec && (op_q == OP_INVAL) && (key_q != '0) && match) begin
      wr_en         = 1'b1;
      wr_data.stamp = '0;
    end
  end

  assign sts_o = '{hash_done: hash_done, sweep_last: sweep_last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= LIFETIME_RESET;
      gen_q      <= '0;
      sweep_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        lifetime_q <= cfg_wdata_i;
      end
      if (cmd_i.gen_inc) begin
        gen_q <= gen_q + 32'd1;
      end
      if (cmd_i.sweep_wr) begin
        sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
      end
    end
  end

  // request capture and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      key_q <= key_id_i;
      now_q <= now_ms_i;
      a_q   <= count_a_in_i;
      b_q   <= count_b_in_i;
      c_q   <= count_c_in_i;
    end
    if (cmd_i.exec) begin
      hit_q <= hit_d;
      oa_q  <= hit_d ? rd_q.cnt_a : '0;
      ob_q  <= hit_d ? rd_q.cnt_b : '0;
      oc_q  <= hit_d ? rd_q.cnt_c : '0;
    end
  end

  // entry memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem[slot];
    end
  end

  assign hit_o         = hit_q;
  assign count_a_out_o = oa_q;
  assign count_b_out_o = ob_q;
  assign count_c_out_o = oc_q;
  assign generation_o  = gen_q[31] ? '0 : gen_q[30:0];

endmodule

`default_nettype wire

FILE: rtl/core/ttlc_ctrl.sv
// ----------------------------------------------------------------------------
// ttlc_ctrl
// Controller: clear sweep after reset, slot hashing wait, entry read and
// update, flush sweep, and the one-cycle result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module ttlc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  ttlc_pkg::op_e      op_i,
  input  ttlc_pkg::dp_sts_t  sts_i,
  output ttlc_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               done_o
);
  import ttlc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_EXEC,
    S_FLUSH
  } state_e;

  state_e state_q;
  logic   done_q;
  logic   accept;

  always_comb begin
    accept         = start_i && (state_q == S_IDLE);
    cmd_o.capture  = accept;
    cmd_o.gen_inc  = accept && (op_i == OP_FLUSH);
    cmd_o.mem_rd   = (state_q == S_HASH) && sts_i.hash_done;
    cmd_o.sweep_wr = (state_q == S_CLEAR) || (state_q == S_FLUSH);
    cmd_o.exec     = (state_q == S_EXEC) || ((state_q == S_FLUSH) && sts_i.sweep_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          if (sts_i.sweep_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            state_q <= (op_i == OP_FLUSH) ? S_FLUSH : S_HASH;
          end
        end
        S_HASH: begin
          if (sts_i.hash_done) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        S_FLUSH: begin
          if (sts_i.sweep_last) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted beat did not raise busy");

  a_read_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_rd |=> (cmd_o.exec && (state_q == S_EXEC)))
    else $error("entry read not followed by update");

  a_flush_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FLUSH) && sts_i.sweep_last) |=> done_o)
    else $error("flush finished without result");

endmodule

`default_nettype wire

FILE: rtl/core/ttl_direct_mapped_count_cache.sv
// ----------------------------------------------------------------------------
// ttl_direct_mapped_count_cache
// Direct-mapped cache of three counts per 32-bit id with an entry lifetime,
// per-id invalidate and a whole-cache flush with a generation counter.
//
//   channel   direction  handshake            beat
//   request   in         start / busy         op_i, key_id_i, now_ms_i, count_*_in_i
//   result    out        done_o (strobe)      hit_o, count_*_out_o, generation_o
//   config    in         cfg_we_i             cfg_wdata_i (lifetime in ms)
//
// store, lookup and invalidate pass from accept through the slot hash, then one
// read and one update of the entry memory, to the strobe; when ENTRIES is not a
// power of two the slot modulo reduces one nibble per cycle.
// flush sweeps the whole memory, one memory entry cleared per cycle.
// after reset busy stays high while the memory is cleared.
// a new request is accepted in the cycle the strobe is shown.
// the receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttl_direct_mapped_count_cache #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] key_id_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [15:0] count_a_in_i,
  input  wire logic [15:0] count_b_in_i,
  input  wire logic [15:0] count_c_in_i,
  output logic             done_o,
  output logic             hit_o,
  output logic      [15:0] count_a_out_o,
  output logic      [15:0] count_b_out_o,
  output logic      [15:0] count_c_out_o,
  output logic      [30:0] generation_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);
  import ttlc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  op_e     op;

  assign op = op_e'(op_i);

  ttlc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (op),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  ttlc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op),
    .key_id_i      (key_id_i),
    .now_ms_i      (now_ms_i),
    .count_a_in_i  (count_a_in_i),
    .count_b_in_i  (count_b_in_i),
    .count_c_in_i  (count_c_in_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .hit_o         (hit_o),
    .count_a_out_o (count_a_out_o),
    .count_b_out_o (count_b_out_o),
    .count_c_out_o (count_c_out_o),
    .generation_o  (generation_o)
  );

endmodule

`default_nettype wire
